// ===== src/ydvr_pkg.sv =====
package ydvr_pkg;

  // Field widths.
  localparam int YAW_W = 17;
  localparam int VEC_W = 15;

  // Angle arithmetic: 360 degrees is 46080 input units.
  localparam int DIFF_W       = 18;
  localparam int ANG_W        = 16;
  localparam int FULL_TURN    = 46080;
  localparam int QUARTER_TURN = 11520;
  localparam int ANGLE_SHIFT  = 9;

  // Vector arithmetic.
  localparam int VEC_SHIFT = 16;
  localparam int XY_W      = 34;
  localparam int Z_W       = 24;

  // Gain correction, K = GAIN_Q30 / 2^30.
  localparam int GAIN_FRAC = 30;
  localparam logic [GAIN_FRAC-1:0] GAIN_Q30 = 30'd652032874;

  // Output range.
  localparam int OUT_MIN = -16384;
  localparam int OUT_MAX = 16383;

  // Rotation stage count and arctangent table size.
  localparam int ROTATION_STAGES = 16;
  localparam int ATAN_LEN        = 24;
  localparam int ATAN_IW         = $clog2(ATAN_LEN);
  localparam int CORDIC_STAGES   =
      (ROTATION_STAGES < ATAN_LEN) ? ROTATION_STAGES : ATAN_LEN;

  // Pipeline: three front stages, the rotation stages, two gain stages.
  localparam int PRE_STAGES = 3;
  localparam int PIPE_DEPTH = PRE_STAGES + CORDIC_STAGES + 2;

  typedef logic signed [YAW_W-1:0] yaw_t;
  typedef logic signed [VEC_W-1:0] vec_t;
  typedef logic signed [XY_W-1:0]  xy_t;
  typedef logic signed [Z_W-1:0]   z_t;

  typedef struct packed {
    logic mul_en;
    logic rnd_en;
  } gain_ctl_t;

  // atan(2^-i) in units of 1/65536 degree, rounded to nearest.
  function automatic z_t atan_at(input logic [ATAN_IW-1:0] idx);
    z_t val;
    case (idx)
      5'd0:    val = 24'sd2949120;
      5'd1:    val = 24'sd1740967;
      5'd2:    val = 24'sd919879;
      5'd3:    val = 24'sd466945;
      5'd4:    val = 24'sd234379;
      5'd5:    val = 24'sd117304;
      5'd6:    val = 24'sd58666;
      5'd7:    val = 24'sd29335;
      5'd8:    val = 24'sd14668;
      5'd9:    val = 24'sd7334;
      5'd10:   val = 24'sd3667;
      5'd11:   val = 24'sd1833;
      5'd12:   val = 24'sd917;
      5'd13:   val = 24'sd458;
      5'd14:   val = 24'sd229;
      5'd15:   val = 24'sd115;
      5'd16:   val = 24'sd57;
      5'd17:   val = 24'sd29;
      5'd18:   val = 24'sd14;
      5'd19:   val = 24'sd7;
      5'd20:   val = 24'sd4;
      5'd21:   val = 24'sd2;
      5'd22:   val = 24'sd1;
      default: val = 24'sd0;
    endcase
    return val;
  endfunction

endpackage

// ===== src/ydvr_in_if.sv =====
interface ydvr_in_if;
  logic             valid;
  logic             ready;
  ydvr_pkg::yaw_t   old_yaw;
  ydvr_pkg::yaw_t   new_yaw;
  ydvr_pkg::vec_t   forward_in;
  ydvr_pkg::vec_t   side_in;

  modport source (output valid, old_yaw, new_yaw, forward_in, side_in, input ready);
  modport sink   (input valid, old_yaw, new_yaw, forward_in, side_in, output ready);
endinterface

// ===== src/ydvr_out_if.sv =====
interface ydvr_out_if;
  logic             valid;
  logic             ready;
  ydvr_pkg::vec_t   forward_out;
  ydvr_pkg::vec_t   side_out;

  modport source (output valid, forward_out, side_out, input ready);
  modport sink   (input valid, forward_out, side_out, output ready);
endinterface

// ===== src/ydvr_gain.sv =====
module ydvr_gain (
  input  logic                clk_i,
  input  ydvr_pkg::gain_ctl_t ctl_i,
  input  ydvr_pkg::xy_t       val_i,
  output ydvr_pkg::vec_t      res_o
);

  // The wide product is built from two narrow partial products.
  localparam int LO_W      = ydvr_pkg::XY_W / 2;
  localparam int HI_W      = ydvr_pkg::XY_W - LO_W;
  localparam int PL_W      = LO_W + ydvr_pkg::GAIN_FRAC;
  localparam int PH_W      = HI_W + ydvr_pkg::GAIN_FRAC;
  localparam int SUM_W     = ydvr_pkg::XY_W + ydvr_pkg::GAIN_FRAC;
  localparam int SUM_SHIFT = ydvr_pkg::VEC_SHIFT + ydvr_pkg::GAIN_FRAC;
  localparam int Q_W       = SUM_W - SUM_SHIFT;

  localparam logic signed [SUM_W-1:0] RND   = SUM_W'(1) <<< (SUM_SHIFT - 1);
  localparam logic signed [Q_W-1:0]   Q_MIN = Q_W'(ydvr_pkg::OUT_MIN);
  localparam logic signed [Q_W-1:0]   Q_MAX = Q_W'(ydvr_pkg::OUT_MAX);

  logic        [LO_W-1:0]  lo;
  logic signed [HI_W-1:0]  hi;
  logic        [PL_W-1:0]  pl_d, pl_q;
  logic signed [PH_W-1:0]  ph_d, ph_q;
  logic signed [SUM_W-1:0] sum;
  logic signed [Q_W-1:0]   quo;
  ydvr_pkg::vec_t          res_d, res_q;

  assign lo   = val_i[LO_W-1:0];
  assign hi   = val_i[ydvr_pkg::XY_W-1:LO_W];
  assign pl_d = lo * ydvr_pkg::GAIN_Q30;
  assign ph_d = hi * $signed({1'b0, ydvr_pkg::GAIN_Q30});

  // Recombine, round to nearest with ties upward, then clamp.
  assign sum = $signed({ph_q, {LO_W{1'b0}}}) + $signed({{HI_W{1'b0}}, pl_q}) + RND;
  assign quo = sum[SUM_W-1:SUM_SHIFT];

  always_comb begin
    if (quo < Q_MIN) begin
      res_d = ydvr_pkg::VEC_W'(Q_MIN);
    end else if (quo > Q_MAX) begin
      res_d = ydvr_pkg::VEC_W'(Q_MAX);
    end else begin
      res_d = ydvr_pkg::VEC_W'(quo);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      pl_q <= pl_d;
      ph_q <= ph_d;
    end
    if (ctl_i.rnd_en) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ===== src/yaw_delta_vector_rotator.sv =====
// Rotates a forward/side movement vector by the yaw change between an old
// and a new yaw (new minus old, taken modulo 360 degrees). Yaws are signed
// in 1/128 degree, movement in 1/16 unit; results saturate to the 15 bit
// field range. The block is a fully pipelined CORDIC rotator: it takes one
// item in every cycle unless a stalled output has filled the pipeline, and
// passes each item through the front, rotation and gain stages in turn.
// Every stage carries its own valid bit and loads whenever it is empty or
// its successor moves on, so a stalled output only stops the stages that
// hold items and the input keeps taking items until the pipeline is full.
module yaw_delta_vector_rotator (
  input  logic              clk_i,
  input  logic              rst_ni,
  ydvr_in_if.sink           in_i,
  ydvr_out_if.source        out_o
);

  localparam int NS    = ydvr_pkg::CORDIC_STAGES;
  localparam int DEPTH = ydvr_pkg::PIPE_DEPTH;
  localparam int GMUL  = ydvr_pkg::PRE_STAGES + NS;
  localparam int GRND  = GMUL + 1;

  localparam logic signed [ydvr_pkg::DIFF_W-1:0] TURN_D =
      ydvr_pkg::DIFF_W'(ydvr_pkg::FULL_TURN);
  localparam logic signed [ydvr_pkg::DIFF_W-1:0] TWO_TURN_D =
      ydvr_pkg::DIFF_W'(2 * ydvr_pkg::FULL_TURN);
  localparam logic [ydvr_pkg::ANG_W-1:0] Q1 = ydvr_pkg::ANG_W'(ydvr_pkg::QUARTER_TURN);
  localparam logic [ydvr_pkg::ANG_W-1:0] Q2 = ydvr_pkg::ANG_W'(2 * ydvr_pkg::QUARTER_TURN);
  localparam logic [ydvr_pkg::ANG_W-1:0] Q3 = ydvr_pkg::ANG_W'(3 * ydvr_pkg::QUARTER_TURN);
  localparam int EXT_W = ydvr_pkg::XY_W - ydvr_pkg::VEC_W - ydvr_pkg::VEC_SHIFT;

  // Handshake chain: a stage may load when it is empty or when the stage
  // after it loads this cycle.
  logic [DEPTH-1:0] v_q;
  logic [DEPTH-1:0] vin;
  logic [DEPTH-1:0] en;
  logic [DEPTH:0]   rdy;

  assign rdy[DEPTH] = out_o.ready;
  assign vin[0]     = in_i.valid;

  for (genvar k = 0; k < DEPTH; k++) begin : g_ctl
    if (k > 0) begin : g_vin
      assign vin[k] = v_q[k-1];
    end
    assign rdy[k] = ~v_q[k] | rdy[k+1];
    assign en[k]  = rdy[k] & vin[k];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < DEPTH; k++) begin
        if (rdy[k]) begin
          v_q[k] <= vin[k];
        end
      end
    end
  end

  assign in_i.ready = rdy[0];

  // Stage 0: bring each yaw into the positive range and take the difference.
  logic signed [ydvr_pkg::DIFF_W-1:0] old_ext, new_ext, old_n, new_n, diff_d, diff_q;
  ydvr_pkg::vec_t fwd0_q, side0_q;

  assign old_ext = ydvr_pkg::DIFF_W'(in_i.old_yaw);
  assign new_ext = ydvr_pkg::DIFF_W'(in_i.new_yaw);
  assign old_n   = old_ext[ydvr_pkg::DIFF_W-1] ? old_ext + TURN_D : old_ext;
  assign new_n   = new_ext[ydvr_pkg::DIFF_W-1] ? new_ext + TURN_D : new_ext;
  assign diff_d  = new_n - old_n;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      diff_q  <= diff_d;
      fwd0_q  <= in_i.forward_in;
      side0_q <= in_i.side_in;
    end
  end

  // Stage 1: the difference lies within two turns either way, so one of
  // four fixed offsets brings it into a single turn.
  logic signed [ydvr_pkg::DIFF_W-1:0] wrap;
  logic [ydvr_pkg::ANG_W-1:0] ang_d, ang_q;
  ydvr_pkg::vec_t fwd1_q, side1_q;

  always_comb begin
    if (diff_q >= TURN_D) begin
      wrap = diff_q - TURN_D;
    end else if (!diff_q[ydvr_pkg::DIFF_W-1]) begin
      wrap = diff_q;
    end else if (diff_q >= -TURN_D) begin
      wrap = diff_q + TURN_D;
    end else begin
      wrap = diff_q + TWO_TURN_D;
    end
  end

  assign ang_d = wrap[ydvr_pkg::ANG_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      ang_q   <= ang_d;
      fwd1_q  <= fwd0_q;
      side1_q <= side0_q;
    end
  end

  // Stage 2: exact quarter-turn rotation; the residue feeds the CORDIC
  // angle accumulator.
  logic [1:0] quad;
  logic [ydvr_pkg::ANG_W-1:0] resid;
  ydvr_pkg::xy_t fx, sx, x_d, y_d;
  ydvr_pkg::z_t  z_d;

  assign fx = {{EXT_W{fwd1_q[ydvr_pkg::VEC_W-1]}}, fwd1_q, {ydvr_pkg::VEC_SHIFT{1'b0}}};
  assign sx = {{EXT_W{side1_q[ydvr_pkg::VEC_W-1]}}, side1_q, {ydvr_pkg::VEC_SHIFT{1'b0}}};

  always_comb begin
    if (ang_q >= Q3) begin
      quad  = 2'd3;
      resid = ang_q - Q3;
    end else if (ang_q >= Q2) begin
      quad  = 2'd2;
      resid = ang_q - Q2;
    end else if (ang_q >= Q1) begin
      quad  = 2'd1;
      resid = ang_q - Q1;
    end else begin
      quad  = 2'd0;
      resid = ang_q;
    end
  end

  always_comb begin
    case (quad)
      2'd1: begin
        x_d = -sx;
        y_d = fx;
      end
      2'd2: begin
        x_d = -fx;
        y_d = -sx;
      end
      2'd3: begin
        x_d = sx;
        y_d = -fx;
      end
      default: begin
        x_d = fx;
        y_d = sx;
      end
    endcase
  end

  assign z_d = ydvr_pkg::Z_W'({resid, {ydvr_pkg::ANGLE_SHIFT{1'b0}}});

  ydvr_pkg::xy_t x_q [NS+1];
  ydvr_pkg::xy_t y_q [NS+1];
  ydvr_pkg::z_t  z_q [NS+1];

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      x_q[0] <= x_d;
      y_q[0] <= y_d;
      z_q[0] <= z_d;
    end
  end

  // Rotation stages: each one turns the vector toward the remaining angle
  // by atan(2^-i), with arithmetic (floor) shifts.
  for (genvar g = 0; g < NS; g++) begin : g_cordic
    ydvr_pkg::xy_t dx, dy;
    ydvr_pkg::z_t  step;

    assign dx   = y_q[g] >>> g;
    assign dy   = x_q[g] >>> g;
    assign step = ydvr_pkg::atan_at(ydvr_pkg::ATAN_IW'(g));

    always_ff @(posedge clk_i) begin
      if (en[ydvr_pkg::PRE_STAGES + g]) begin
        if (!z_q[g][ydvr_pkg::Z_W-1]) begin
          x_q[g+1] <= x_q[g] - dx;
          y_q[g+1] <= y_q[g] + dy;
          z_q[g+1] <= z_q[g] - step;
        end else begin
          x_q[g+1] <= x_q[g] + dx;
          y_q[g+1] <= y_q[g] - dy;
          z_q[g+1] <= z_q[g] + step;
        end
      end
    end
  end

  // Gain correction: multiply, then round and saturate into the output
  // register.
  ydvr_pkg::gain_ctl_t gain_ctl;

  assign gain_ctl.mul_en = en[GMUL];
  assign gain_ctl.rnd_en = en[GRND];

  ydvr_gain u_gain_fwd (
    .clk_i (clk_i),
    .ctl_i (gain_ctl),
    .val_i (x_q[NS]),
    .res_o (out_o.forward_out)
  );

  ydvr_gain u_gain_side (
    .clk_i (clk_i),
    .ctl_i (gain_ctl),
    .val_i (y_q[NS]),
    .res_o (out_o.side_out)
  );

  assign out_o.valid = v_q[DEPTH-1];

endmodule

// ===== src/ydvr_checker.sv =====
module ydvr_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_i,
  input logic           out_valid_i,
  input logic           out_ready_i,
  input ydvr_pkg::vec_t fwd_i,
  input ydvr_pkg::vec_t side_i
);

  localparam int CNT_W = $clog2(ydvr_pkg::PIPE_DEPTH + 1);

  logic             in_acc, out_acc;
  logic [CNT_W-1:0] cnt_d, cnt_q;

  assign in_acc  = in_valid_i & in_ready_i;
  assign out_acc = out_valid_i & out_ready_i;
  assign cnt_d   = cnt_q + CNT_W'(in_acc) - CNT_W'(out_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Reset empties the pipeline by the next clock edge at the latest.
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("result shown during reset");

  // No result without an item in flight.
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cnt_q != '0)
    else $error("result without an accepted item");

  // The input is open whenever the pipeline has room or the output drains.
  a_no_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q < ydvr_pkg::PIPE_DEPTH || out_ready_i) |-> in_ready_i)
    else $error("input closed with room in the pipeline");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(fwd_i) && $stable(side_i))
    else $error("stalled result changed");

endmodule

bind yaw_delta_vector_rotator ydvr_checker u_ydvr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .fwd_i       (out_o.forward_out),
  .side_i      (out_o.side_out)
);

// ===== dv/ydvr_motion_check.sv =====
`timescale 1ns / 1ps

module ydvr_motion_check
  import ydvr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  ydvr_in_if         in_ch_i,
  ydvr_out_if        out_ch_i,
  output int         fail_cnt_o,
  output int         pending_cnt_o,
  output int         checked_cnt_o,
  output int         clipped_cnt_o,
  output logic [3:0] quadrants_o
);

  typedef struct {
    yaw_t old_yaw;
    yaw_t new_yaw;
    vec_t forward;
    vec_t side;
  } motion_t;

  // atan(2^-i) in 1/65536 degree, rounded to nearest.
  longint arc_q16 [ATAN_LEN] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  motion_t    rotated_q [$];
  int         fails = 0;
  int         pending = 0;
  int         checked = 0;
  int         clipped = 0;
  logic [3:0] quads = '0;

  assign fail_cnt_o    = fails;
  assign pending_cnt_o = pending;
  assign checked_cnt_o = checked;
  assign clipped_cnt_o = clipped;
  assign quadrants_o   = quads;

  // Gain correction, rounding half up, and clipping to the field range.
  function automatic vec_t scale_to_field(input longint acc, output bit clip);
    longint prod;
    longint rounded;
    prod    = acc * longint'(GAIN_Q30);
    rounded = (prod + (longint'(1) <<< (GAIN_FRAC + VEC_SHIFT - 1)))
              >>> (GAIN_FRAC + VEC_SHIFT);
    clip    = 1'b0;
    if (rounded < OUT_MIN) begin
      rounded = OUT_MIN;
      clip    = 1'b1;
    end else if (rounded > OUT_MAX) begin
      rounded = OUT_MAX;
      clip    = 1'b1;
    end
    return vec_t'(rounded);
  endfunction

  function automatic motion_t rotate_by_yaw_delta(input yaw_t old_yaw, input yaw_t new_yaw,
                                                   input vec_t fwd, input vec_t sid,
                                                   output int quadrant, output bit clip);
    longint  from_ang;
    longint  to_ang;
    longint  delta;
    longint  resid;
    longint  x;
    longint  y;
    longint  t;
    longint  dx;
    longint  dy;
    int      stages;
    int      k;
    int      i;
    bit      clip_f;
    bit      clip_s;
    motion_t res;
    from_ang = old_yaw;
    to_ang   = new_yaw;
    if (from_ang < 0) from_ang += FULL_TURN;
    if (to_ang < 0) to_ang += FULL_TURN;
    delta = (to_ang - from_ang) % FULL_TURN;
    if (delta < 0) delta += FULL_TURN;

    quadrant = int'(delta / QUARTER_TURN);
    resid    = (delta - longint'(quadrant) * QUARTER_TURN) * (longint'(1) <<< ANGLE_SHIFT);

    x = longint'(fwd) * (longint'(1) <<< VEC_SHIFT);
    y = longint'(sid) * (longint'(1) <<< VEC_SHIFT);
    for (k = 0; k < quadrant; k++) begin
      t = x;
      x = -y;
      y = t;
    end

    stages = (ROTATION_STAGES < ATAN_LEN) ? ROTATION_STAGES : ATAN_LEN;
    for (i = 0; i < stages; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (resid >= 0) begin
        x     -= dx;
        y     += dy;
        resid -= arc_q16[i];
      end else begin
        x     += dx;
        y     -= dy;
        resid += arc_q16[i];
      end
    end

    res.old_yaw = old_yaw;
    res.new_yaw = new_yaw;
    res.forward = scale_to_field(x, clip_f);
    res.side    = scale_to_field(y, clip_s);
    clip        = clip_f | clip_s;
    return res;
  endfunction

  always @(posedge clk_i) begin
    motion_t want;
    int      quad;
    bit      clip;
    vec_t    got_fwd;
    vec_t    got_side;
    if (rst_ni) begin
      if (in_ch_i.valid && in_ch_i.ready) begin
        want = rotate_by_yaw_delta(in_ch_i.old_yaw, in_ch_i.new_yaw,
                                   in_ch_i.forward_in, in_ch_i.side_in, quad, clip);
        rotated_q.push_back(want);
        quads[quad] = 1'b1;
        if (clip) clipped++;
      end
      if (out_ch_i.valid && out_ch_i.ready) begin
        got_fwd  = out_ch_i.forward_out;
        got_side = out_ch_i.side_out;
        if (rotated_q.size() == 0) begin
          fails++;
          $display("%0t: result with no item outstanding: forward %0d side %0d",
                   $time, got_fwd, got_side);
        end else begin
          want = rotated_q.pop_front();
          checked++;
          if (got_fwd !== want.forward) begin
            fails++;
            $display("%0t: forward_out mismatch (yaw %0d -> %0d): expected %0d, actual %0d",
                     $time, want.old_yaw, want.new_yaw, want.forward, got_fwd);
          end
          if (got_side !== want.side) begin
            fails++;
            $display("%0t: side_out mismatch (yaw %0d -> %0d): expected %0d, actual %0d",
                     $time, want.old_yaw, want.new_yaw, want.side, got_side);
          end
        end
      end
      pending = rotated_q.size();
    end
  end

endmodule

// ===== dv/yaw_delta_vector_rotator_tb.sv =====
`timescale 1ns / 1ps

module yaw_delta_vector_rotator_tb;
  import ydvr_pkg::*;

  // Stimulus volume and the shape of the idle pattern on both sides.
  localparam int ITEM_TOTAL   = 1950;
  localparam int IDLE_PCT     = 17;
  // The output side stops taking results for a long stretch starting here,
  // so the pipeline fills and the input has to stall.
  localparam int HOLD_AT      = 800;
  localparam int HOLD_CYCLES  = 300;
  // Window of cycles in which neither side idles, to run the pipeline flat out.
  localparam int CALM_FROM    = 1600;
  localparam int CALM_TO      = 2100;
  // After the last result, run on for DRAIN_CYCLES to
  // show any stray result.
  localparam int DRAIN_CYCLES = PIPE_DEPTH + 10;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned cyc = 0;
  int          sent = 0;
  int          fails;
  int          pending;
  int          checked;
  int          clipped;
  logic [3:0]  quads;

  ydvr_in_if  in_ch ();
  ydvr_out_if out_ch ();

  yaw_delta_vector_rotator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // The prediction and comparison live in their own module; this top only
  // makes stimulus and reads back the tallies for the verdict.
  ydvr_motion_check u_motion_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_ch_i       (in_ch),
    .out_ch_i      (out_ch),
    .fail_cnt_o    (fails),
    .pending_cnt_o (pending),
    .checked_cnt_o (checked),
    .clipped_cnt_o (clipped),
    .quadrants_o   (quads)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
  end

  function automatic bit calm_now();
    return (cyc >= CALM_FROM) && (cyc < CALM_TO);
  endfunction

  // Offers one item. The task is entered at a falling edge and returns at the
  // falling edge after the item was taken, so valid stays high into the next
  // item unless that one starts with an idle cycle. While idle, the old yaw and
  // forward input are scrambled to show that the block ignores them without valid.
  task automatic offer_item(input yaw_t old_yaw, input yaw_t new_yaw,
                            input vec_t fwd, input vec_t sid);
    while (!calm_now() && ($urandom_range(99) < IDLE_PCT)) begin
      in_ch.valid      <= 1'b0;
      in_ch.old_yaw    <= yaw_t'($urandom());
      in_ch.forward_in <= vec_t'($urandom());
      @(negedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.old_yaw    <= old_yaw;
    in_ch.new_yaw    <= new_yaw;
    in_ch.forward_in <= fwd;
    in_ch.side_in    <= sid;
    // Ready is read right at the rising edge, before the block updates it,
    // which is the value that decides the handshake at that edge.
    do @(posedge clk_i); while (!in_ch.ready);
    sent++;
    @(negedge clk_i);
  endtask

  // Mostly full-range movement, with a share of the field extremes, zero and -1, and of
  // small vectors where rounding of the rotation shows most.
  function automatic vec_t random_motion();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return vec_t'($urandom());
      6, 7: begin
        case ($urandom_range(3))
          0:       return vec_t'(OUT_MIN);
          1:       return vec_t'(OUT_MAX);
          2:       return '0;
          default: return '1;
        endcase
      end
      default: return vec_t'(int'($urandom_range(64)) - 32);
    endcase
  endfunction

  // Yaw pairs: most within the stated -180..360 degree range, some anywhere
  // in the 17 bit field, and some a few units off an exact quarter turn
  // apart so the quadrant split and its boundaries get hit often.
  task automatic offer_random_item();
    int unsigned pick;
    int          base;
    int          step;
    yaw_t        old_yaw;
    yaw_t        new_yaw;
    pick = $urandom_range(9);
    if (pick <= 5) begin
      old_yaw = yaw_t'(int'($urandom_range(69119)) - 23040);
      new_yaw = yaw_t'(int'($urandom_range(69119)) - 23040);
    end else if (pick <= 7) begin
      old_yaw = yaw_t'($urandom());
      new_yaw = yaw_t'($urandom());
    end else begin
      base    = int'($urandom_range(69119)) - 23040;
      step    = int'($urandom_range(3)) * QUARTER_TURN + int'($urandom_range(8)) - 4;
      old_yaw = yaw_t'(base);
      new_yaw = yaw_t'(base + step);
    end
    offer_item(old_yaw, new_yaw, random_motion(), random_motion());
  endtask

  // Output side. Mostly random back-pressure, one long hold-off counted here
  // while the input keeps offering items, and a window with ready held high.
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left    = 0;
    hold_done    = 1'b0;
    out_ch.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (!hold_done && (cyc >= HOLD_AT)) begin
        out_ch.ready <= 1'b0;
        hold_left = HOLD_CYCLES - 1;
        hold_done = 1'b1;
      end else if (calm_now()) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Input side: reset, a directed set, then random items, then the verdict.
  initial begin
    rst_ni           = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.old_yaw    = '0;
    in_ch.new_yaw    = '0;
    in_ch.forward_in = '0;
    in_ch.side_in    = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Equal yaws: the vector passes through, up to rounding.
    offer_item(yaw_t'(0), yaw_t'(0), vec_t'(OUT_MAX), vec_t'(0));
    offer_item(yaw_t'(0), yaw_t'(0), vec_t'(OUT_MIN), vec_t'(OUT_MIN));
    offer_item(yaw_t'(-23040), yaw_t'(-23040), vec_t'(12345), vec_t'(-5432));
    offer_item(yaw_t'(46079), yaw_t'(46079), vec_t'(-1), vec_t'(1));
    // Exact quarter, half and three-quarter turns, and either side of one.
    offer_item(yaw_t'(0), yaw_t'(11520), vec_t'(OUT_MAX), vec_t'(0));
    offer_item(yaw_t'(0), yaw_t'(23040), vec_t'(1000), vec_t'(-2000));
    offer_item(yaw_t'(0), yaw_t'(34560), vec_t'(OUT_MIN), vec_t'(OUT_MAX));
    offer_item(yaw_t'(0), yaw_t'(11519), vec_t'(8000), vec_t'(8000));
    offer_item(yaw_t'(0), yaw_t'(11521), vec_t'(-8000), vec_t'(8000));
    // Half turn of the most negative vector runs past the positive limit.
    offer_item(yaw_t'(0), yaw_t'(23040), vec_t'(OUT_MIN), vec_t'(OUT_MIN));
    // Extremes of the stated yaw range, negative yaws wrapped by a full turn.
    offer_item(yaw_t'(46079), yaw_t'(-23040), vec_t'(100), vec_t'(200));
    offer_item(yaw_t'(-23040), yaw_t'(46079), vec_t'(-300), vec_t'(400));
    offer_item(yaw_t'(-1), yaw_t'(0), vec_t'(OUT_MAX), vec_t'(OUT_MIN));
    offer_item(yaw_t'(0), yaw_t'(46079), vec_t'(1), vec_t'(-1));
    // Yaws outside the stated range, at the ends of the 17 bit field.
    offer_item(yaw_t'(-65536), yaw_t'(65535), vec_t'(OUT_MAX), vec_t'(OUT_MAX));
    offer_item(yaw_t'(65535), yaw_t'(-65536), vec_t'(OUT_MIN), vec_t'(OUT_MAX));
    // 45 and 135 degrees on full-scale vectors: one output clips.
    offer_item(yaw_t'(0), yaw_t'(5760), vec_t'(OUT_MAX), vec_t'(OUT_MAX));
    offer_item(yaw_t'(0), yaw_t'(17280), vec_t'(OUT_MIN), vec_t'(OUT_MIN));
    // Zero vector and a few mixed cases.
    offer_item(yaw_t'(0), yaw_t'(45), vec_t'(0), vec_t'(0));
    offer_item(yaw_t'(12000), yaw_t'(1000), vec_t'(OUT_MAX), vec_t'(OUT_MIN));
    offer_item(yaw_t'(-100), yaw_t'(30000), vec_t'(OUT_MIN), vec_t'(0));

    while (sent < ITEM_TOTAL) begin
      offer_random_item();
    end
    in_ch.valid <= 1'b0;

    // Every accepted item leaves an expectation until its result arrives.
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Rotated %0d items; %0d results compared, %0d of them with a clipped field.",
             sent, checked, clipped);
    $display("Quadrants of the yaw change reached: %b; output held off for %0d cycles once.",
             quads, HOLD_CYCLES);
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== yaw_delta_vector_rotator.f =====
src/ydvr_pkg.sv
src/ydvr_in_if.sv
src/ydvr_out_if.sv
src/ydvr_gain.sv
src/yaw_delta_vector_rotator.sv
src/ydvr_checker.sv
dv/ydvr_motion_check.sv
dv/yaw_delta_vector_rotator_tb.sv
